FILE: src/sg_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package sg_pkg;

  localparam int SampleW = 24;
  localparam int GateW   = 22;
  localparam int CoefW   = 32;
  localparam int BaseW   = 21;
  localparam int ProdW   = 59;
  localparam int OpAW    = 26;
  localparam int OpBW    = 33;

  localparam logic [GateW-1:0] GATE_OPEN = 22'd1153434;
  localparam logic [GateW-1:0] GATE_MAX  = 22'd4194303;
  localparam logic [GateW-1:0] GATE_ONE  = 22'd1048576;
  localparam logic [CoefW-1:0] Q31_ONE   = 32'h8000_0000;

  // Register indexes on the configuration port.
  localparam logic [1:0] CFG_THRESHOLD  = 2'd0;
  localparam logic [1:0] CFG_RECOVERY   = 2'd1;
  localparam logic [1:0] CFG_BASELINE   = 2'd2;
  localparam logic [1:0] CFG_LEVEL_GAIN = 2'd3;

  localparam logic [CoefW-1:0] THRESHOLD_RST  = 32'd33554432;
  localparam logic [CoefW-1:0] INVREC_RST     = 32'd2146959360;
  localparam logic [BaseW-1:0] B20_RST        = 21'd0;
  localparam logic [CoefW-1:0] LEVEL_GAIN_RST = 32'd262144;

  typedef struct packed {
    logic signed [SampleW-1:0] sample_left;
    logic signed [SampleW-1:0] sample_right;
  } sg_in_t;

  typedef struct packed {
    logic signed [SampleW-1:0] out_left;
    logic signed [SampleW-1:0] out_right;
  } sg_out_t;

  // Configuration as the datapath uses it: recovery is kept as its decay
  // factor and baseline is kept already rounded to Q1.20.
  typedef struct packed {
    logic [CoefW-1:0] threshold;
    logic [CoefW-1:0] invrec;
    logic [BaseW-1:0] b20;
    logic [CoefW-1:0] level_gain;
  } sg_cfg_t;

  typedef enum logic [3:0] {
    MUL_NONE,
    MUL_LVL,
    MUL_DEC0,
    MUL_DEC1,
    MUL_HL,
    MUL_HR,
    MUL_XL,
    MUL_ML,
    MUL_XR,
    MUL_MR
  } sg_mul_e;

  typedef enum logic [3:0] {
    POST_NONE,
    POST_LVL,
    POST_G1,
    POST_G,
    POST_HL,
    POST_HR,
    POST_ACC,
    POST_OUTL,
    POST_OUTR
  } sg_post_e;

  typedef struct packed {
    logic     load_in;
    logic     prep;
    sg_mul_e  mul_sel;
    sg_post_e post_sel;
    logic     load_out;
  } sg_cmd_t;

  typedef struct packed {
    logic ge_one;
  } sg_status_t;

  // Arithmetic shift right by s, rounding to nearest with ties away from zero.
  function automatic logic signed [ProdW-1:0] rnd_shr(input logic signed [ProdW-1:0] v,
                                                      input logic [5:0] s);
    logic             neg;
    logic [ProdW-1:0] m;
    logic [ProdW-1:0] half;
    neg  = v[ProdW-1];
    m    = neg ? ProdW'(-v) : ProdW'(v);
    half = ProdW'(1) << (s - 6'd1);
    m    = (m + half) >> s;
    rnd_shr = neg ? -$signed(m) : $signed(m);
  endfunction

  function automatic logic signed [SampleW-1:0] sat24(input logic signed [ProdW-1:0] v);
    if (v > 59'sd8388607) begin
      sat24 = 24'sh7FFFFF;
    end else if (v < -59'sd8388608) begin
      sat24 = 24'sh800000;
    end else begin
      sat24 = v[SampleW-1:0];
    end
  endfunction

endpackage

`default_nettype wire

FILE: src/sg_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module sg_ctrl (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                in_valid_i,
  output logic               in_stall_o,
  output logic               out_valid_o,
  input  wire                out_stall_i,
  input  sg_pkg::sg_status_t status_i,
  output sg_pkg::sg_cmd_t    cmd_o
);
  import sg_pkg::*;

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_PREP = 4'd1;
  localparam logic [3:0] ST_DEC0 = 4'd2;
  localparam logic [3:0] ST_G1   = 4'd3;
  localparam logic [3:0] ST_DEC1 = 4'd4;
  localparam logic [3:0] ST_G    = 4'd5;
  localparam logic [3:0] ST_HL   = 4'd6;
  localparam logic [3:0] ST_HR   = 4'd7;
  localparam logic [3:0] ST_XL   = 4'd8;
  localparam logic [3:0] ST_ML   = 4'd9;
  localparam logic [3:0] ST_XR   = 4'd10;
  localparam logic [3:0] ST_MR   = 4'd11;
  localparam logic [3:0] ST_OUTR = 4'd12;
  localparam logic [3:0] ST_DONE = 4'd13;

  logic [3:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;

  // Each state issues at most one multiply and consumes, if any, the product of the state before.
  always_comb begin
    state_d        = state_q;
    cmd_o.load_in  = 1'b0;
    cmd_o.prep     = 1'b0;
    cmd_o.mul_sel  = MUL_NONE;
    cmd_o.post_sel = POST_NONE;
    cmd_o.load_out = 1'b0;
    case (state_q)
      ST_IDLE: begin
        cmd_o.load_in = in_valid_i;
        if (in_valid_i) state_d = ST_PREP;
      end
      ST_PREP: begin
        cmd_o.prep    = 1'b1;
        cmd_o.mul_sel = MUL_LVL;
        state_d       = ST_DEC0;
      end
      ST_DEC0: begin
        cmd_o.mul_sel  = MUL_DEC0;
        cmd_o.post_sel = POST_LVL;
        state_d        = ST_G1;
      end
      ST_G1: begin
        cmd_o.post_sel = POST_G1;
        state_d        = ST_DEC1;
      end
      ST_DEC1: begin
        cmd_o.mul_sel = MUL_DEC1;
        state_d       = ST_G;
      end
      ST_G: begin
        cmd_o.post_sel = POST_G;
        state_d        = status_i.ge_one ? ST_DONE : ST_HL;
      end
      ST_HL: begin
        cmd_o.mul_sel = MUL_HL;
        state_d       = ST_HR;
      end
      ST_HR: begin
        cmd_o.mul_sel  = MUL_HR;
        cmd_o.post_sel = POST_HL;
        state_d        = ST_XL;
      end
      ST_XL: begin
        cmd_o.mul_sel  = MUL_XL;
        cmd_o.post_sel = POST_HR;
        state_d        = ST_ML;
      end
      ST_ML: begin
        cmd_o.mul_sel  = MUL_ML;
        cmd_o.post_sel = POST_ACC;
        state_d        = ST_XR;
      end
      ST_XR: begin
        cmd_o.mul_sel  = MUL_XR;
        cmd_o.post_sel = POST_OUTL;
        state_d        = ST_MR;
      end
      ST_MR: begin
        cmd_o.mul_sel  = MUL_MR;
        cmd_o.post_sel = POST_ACC;
        state_d        = ST_OUTR;
      end
      ST_OUTR: begin
        cmd_o.post_sel = POST_OUTR;
        state_d        = ST_DONE;
      end
      ST_DONE: begin
        // The result waits here until the output register is free.
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.load_out = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) out_valid_d = 1'b0;
    if (cmd_o.load_out) out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

`default_nettype wire

FILE: src/sg_dp.sv
`timescale 1ns / 1ps
`default_nettype none

module sg_dp (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  sg_pkg::sg_cfg_t    cfg_i,
  input  sg_pkg::sg_cmd_t    cmd_i,
  input  sg_pkg::sg_in_t     in_data_i,
  output sg_pkg::sg_status_t status_o,
  output sg_pkg::sg_out_t    out_data_o
);
  import sg_pkg::*;

  // Channel state.
  logic signed [SampleW-1:0] held_l_q, held_r_q;
  logic [GateW-1:0]          gate_q;

  // Working registers for the item in flight.
  logic signed [SampleW-1:0] xl_q, xr_q;
  logic [SampleW:0]          sum_mag_q;
  logic signed [SampleW:0]   dl_q, dr_q;
  logic signed [23:0]        diffg_q;
  logic [30:0]               lvl_q;
  logic                      open_q;
  logic [GateW-1:0]          gw_q;
  logic signed [ProdW-1:0]   prod_q, acc_q;
  logic signed [SampleW-1:0] res_l_q, res_r_q;
  sg_out_t                   out_q;

  logic signed [OpAW-1:0]    op_a;
  logic signed [OpBW-1:0]    op_b;
  logic signed [ProdW-1:0]   prod_d;
  logic [SampleW-1:0]        abs_l, abs_r;
  logic [SampleW:0]          mag_dl, mag_dr;
  logic signed [ProdW-1:0]   rs31, rs27, rs20, blend;
  logic signed [SampleW:0]   g1_full;
  logic [31:0]               g_sum;
  logic [GateW-1:0]          g_new;
  logic [20:0]               one_m_g;

  assign abs_l = in_data_i.sample_left[SampleW-1]
               ? SampleW'(-in_data_i.sample_left) : in_data_i.sample_left;
  assign abs_r = in_data_i.sample_right[SampleW-1]
               ? SampleW'(-in_data_i.sample_right) : in_data_i.sample_right;

  assign mag_dl = dl_q[SampleW] ? (SampleW+1)'(-dl_q) : dl_q;
  assign mag_dr = dr_q[SampleW] ? (SampleW+1)'(-dr_q) : dr_q;

  assign one_m_g = 21'(GATE_ONE) - {1'b0, gw_q[19:0]};

  // Operand selection for the one shared multiplier.
  always_comb begin
    op_a = '0;
    op_b = '0;
    case (cmd_i.mul_sel)
      MUL_LVL: begin
        op_a = {1'b0, sum_mag_q};
        op_b = {1'b0, cfg_i.level_gain};
      end
      MUL_DEC0: begin
        op_a = {{2{diffg_q[23]}}, diffg_q};
        op_b = {1'b0, cfg_i.invrec};
      end
      MUL_DEC1: begin
        op_a = {4'b0, gw_q};
        op_b = {1'b0, cfg_i.invrec};
      end
      MUL_HL: begin
        op_a = {dl_q[SampleW], dl_q};
        op_b = {11'b0, gw_q};
      end
      MUL_HR: begin
        op_a = {dr_q[SampleW], dr_q};
        op_b = {11'b0, gw_q};
      end
      MUL_XL: begin
        op_a = {{2{xl_q[SampleW-1]}}, xl_q};
        op_b = {11'b0, gw_q};
      end
      MUL_ML: begin
        op_a = {{2{held_l_q[SampleW-1]}}, held_l_q};
        op_b = {12'b0, one_m_g};
      end
      MUL_XR: begin
        op_a = {{2{xr_q[SampleW-1]}}, xr_q};
        op_b = {11'b0, gw_q};
      end
      MUL_MR: begin
        op_a = {{2{held_r_q[SampleW-1]}}, held_r_q};
        op_b = {12'b0, one_m_g};
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  assign prod_d = op_a * op_b;

  assign rs31  = rnd_shr(prod_q, 6'd31);
  assign rs27  = rnd_shr(prod_q, 6'd27);
  assign rs20  = rnd_shr(prod_q, 6'd20);
  assign blend = rnd_shr(acc_q + prod_q, 6'd20);

  // The decay toward baseline is skipped while the gate sits at zero.
  assign g1_full = (gate_q == '0) ? '0
                 : (SampleW+1)'(rs31[SampleW:0] + {4'b0, cfg_i.b20});

  assign g_sum = 32'(rs31[GateW-1:0]) + 32'(lvl_q);
  assign g_new = open_q ? GATE_OPEN
               : (g_sum > 32'(GATE_MAX)) ? GATE_MAX : g_sum[GateW-1:0];

  assign status_o.ge_one = (g_new >= GATE_ONE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_l_q <= '0;
      held_r_q <= '0;
      gate_q   <= GATE_OPEN;
    end else begin
      case (cmd_i.post_sel)
        POST_G: begin
          gate_q <= g_new;
          if (status_o.ge_one) begin
            held_l_q <= xl_q;
            held_r_q <= xr_q;
          end
        end
        POST_HL: held_l_q <= sat24(ProdW'(held_l_q) + rs20);
        POST_HR: held_r_q <= sat24(ProdW'(held_r_q) + rs20);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    if (cmd_i.load_in) begin
      xl_q      <= in_data_i.sample_left;
      xr_q      <= in_data_i.sample_right;
      sum_mag_q <= {1'b0, abs_l} + {1'b0, abs_r};
    end
    if (cmd_i.prep) begin
      dl_q    <= {xl_q[SampleW-1], xl_q} - {held_l_q[SampleW-1], held_l_q};
      dr_q    <= {xr_q[SampleW-1], xr_q} - {held_r_q[SampleW-1], held_r_q};
      diffg_q <= {2'b0, gate_q} - {3'b0, cfg_i.b20};
    end
    case (cmd_i.post_sel)
      POST_LVL: begin
        lvl_q  <= (cfg_i.threshold != '0) ? rs27[30:0] : '0;
        open_q <= ({mag_dl, 8'b0} > {1'b0, cfg_i.threshold})
               || ({mag_dr, 8'b0} > {1'b0, cfg_i.threshold});
      end
      POST_G1: gw_q <= g1_full[GateW-1:0];
      POST_G: begin
        gw_q <= g_new;
        if (status_o.ge_one) begin
          res_l_q <= xl_q;
          res_r_q <= xr_q;
        end
      end
      POST_ACC:  acc_q   <= prod_q;
      POST_OUTL: res_l_q <= sat24(blend);
      POST_OUTR: res_r_q <= sat24(blend);
      default: ;
    endcase
    if (cmd_i.load_out) begin
      out_q.out_left  <= res_l_q;
      out_q.out_right <= res_r_q;
    end
  end

  assign out_data_o = out_q;

endmodule

`default_nettype wire

FILE: src/stereo_soft_gate_core.sv
`timescale 1ns / 1ps
`default_nettype none

// Soft gate for one stereo sample pair per transfer.
// Input channel: in_valid_i / in_stall_o carry a pair of Q1.23 samples; a
// transfer takes place when valid is high and stall is low. Output channel:
// out_valid_o / out_stall_i carry the gated pair from an output register.
// The block works on one item at a time, sequenced by a controller around a
// single shared 26 x 33 bit multiplier with at most one multiply per cycle.
// When the new gate is 1.0 or more the input pair is registered as the result
// unchanged; below 1.0 the slew and blend first add six multiplies. The next
// item may be taken only after the result is registered.
// A finished result sits in the output register while the next item is
// taken; if the receiver still stalls when the following result is ready,
// the controller holds it and keeps in_stall_o high until the register frees.
// Configuration writes (cfg_we_i, cfg_idx_i, cfg_data_i) take effect at once
// and must be made while the block is idle.
// Reset restores the default registers, clears the held samples, opens the
// gate to 1.1 and empties the output register.

module stereo_soft_gate_core (
  input  wire             clk_i,
  input  wire             rst_ni,
  input  wire             in_valid_i,
  output logic            in_stall_o,
  input  sg_pkg::sg_in_t  in_data_i,
  output logic            out_valid_o,
  input  wire             out_stall_i,
  output sg_pkg::sg_out_t out_data_o,
  input  wire             cfg_we_i,
  input  wire [1:0]       cfg_idx_i,
  input  wire [31:0]      cfg_data_i
);
  import sg_pkg::*;

  logic [CoefW-1:0] threshold_q, invrec_q, level_gain_q;
  logic [BaseW-1:0] b20_q;
  logic [CoefW-1:0] coef_clamp;
  logic [CoefW-1:0] base_sum;
  sg_cfg_t          cfg;
  sg_cmd_t          cmd;
  sg_status_t       status;

  // Recovery and baseline coefficients above one act as one.
  assign coef_clamp = (cfg_data_i > Q31_ONE) ? Q31_ONE : cfg_data_i;
  assign base_sum   = coef_clamp + 32'd1024;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      threshold_q  <= THRESHOLD_RST;
      invrec_q     <= INVREC_RST;
      b20_q        <= B20_RST;
      level_gain_q <= LEVEL_GAIN_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_THRESHOLD:  threshold_q  <= cfg_data_i;
        CFG_RECOVERY:   invrec_q     <= Q31_ONE - coef_clamp;
        CFG_BASELINE:   b20_q        <= base_sum[31:11];
        CFG_LEVEL_GAIN: level_gain_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign cfg.threshold  = threshold_q;
  assign cfg.invrec     = invrec_q;
  assign cfg.b20        = b20_q;
  assign cfg.level_gain = level_gain_q;

  sg_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  sg_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .cmd_i      (cmd),
    .in_data_i  (in_data_i),
    .status_o   (status),
    .out_data_o (out_data_o)
  );

  // An accepted item keeps the input side busy in the following cycle.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input not stalled after a transfer");

  // A new result appears only as the controller returns to idle.
  a_result_frees_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> !in_stall_o && $past(in_stall_o))
    else $error("result appeared outside the end of an item");

  // No result is produced while the block is idle with nothing pending.
  a_no_spurious_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_stall_o && !out_valid_o && !(in_valid_i) |=> !out_valid_o)
    else $error("result without an item in flight");

endmodule

`default_nettype wire
